/* rtl/vtpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpg_pkg
// shared types and constants of the video test pattern generator
// ----------------------------------------------------------------------------
package vtpg_pkg;

	localparam int COORD_W = 10;
	localparam int COLOR_W = 16;
	localparam int SEL_W   = 2;

	localparam logic [SEL_W-1:0] PAT_GRADIENT = 2'd1;
	localparam logic [SEL_W-1:0] PAT_BARS     = 2'd2;
	localparam logic [SEL_W-1:0] PAT_LADDER   = 2'd3;

	localparam logic [COLOR_W-1:0] WHITE565 = 16'hFFFF;
	localparam logic [COLOR_W-1:0] GREY565  = 16'h7BEF;
	localparam logic [COLOR_W-1:0] BLACK565 = 16'h0000;
	localparam logic [COLOR_W-1:0] RED565   = 16'hF800;
	localparam logic [COLOR_W-1:0] GREEN565 = 16'h07E0;
	localparam logic [COLOR_W-1:0] BLUE565  = 16'h001F;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [SEL_W-1:0]   sel;
	} pix_t;

	typedef struct packed {
		logic [7:0]         red;
		logic [7:0]         blue;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               col_edge;
		logic               row_edge;
	} grid_t;

endpackage

/* rtl/video_test_pattern_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_test_pattern_generator
// gives the RGB565 color of one pixel in the selected test pattern
// ----------------------------------------------------------------------------
// channel   ports                          handshake
// input     pixel_x, pixel_y               start & !busy
// result    pixel_color                    done, one cycle
// config    cfg_wr_en, cfg_wr_data         cfg_wr_en
//
// one beat per clock; each result is registered through the three-stage
// constant dividers and then the color stage
// busy stays low, the pipeline never stalls
// reset clears the valid bits and selects the bit-ladder pattern
// ----------------------------------------------------------------------------
module video_test_pattern_generator #(
	parameter int H_ACTIVE = 720,
	parameter int V_ACTIVE = 720
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  pixel_x,
	input  logic [9:0]  pixel_y,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	output logic        done,
	output logic [15:0] pixel_color
);
	import vtpg_pkg::*;

	localparam int NW_GRAD = COORD_W + 8;

	logic [SEL_W-1:0]   sel_q;
	logic               accept;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	pix_t               pix_in;
	pix_t               pix_s1;
	pix_t               pix_s2;
	pix_t               pix_s3;
	grid_t              grid;
	logic [NW_GRAD-1:0] nx;
	logic [NW_GRAD-1:0] ny;
	logic [NW_GRAD-1:0] rq;
	logic [NW_GRAD-1:0] rr;
	logic [NW_GRAD-1:0] bq;
	logic [NW_GRAD-1:0] br;
	logic [COORD_W-1:0] cq;
	logic [COORD_W-1:0] cr;
	logic [COORD_W-1:0] wq;
	logic [COORD_W-1:0] wr;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= PAT_LADDER;
		end else if (cfg_wr_en) begin
			sel_q <= cfg_wr_data;
		end
	end

	assign pix_in = '{x: pixel_x, y: pixel_y, sel: sel_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pix_in;
		pix_s2 <= pix_s1;
		pix_s3 <= pix_s2;
	end

	// coordinate times 255
	assign nx = {pixel_x, 8'd0} - NW_GRAD'(pixel_x);
	assign ny = {pixel_y, 8'd0} - NW_GRAD'(pixel_y);

	vtpg_cdiv #(.NW(NW_GRAD), .DIV(H_ACTIVE - 1)) u_red_div (
		.clk (clk),
		.num (nx),
		.quo (rq),
		.rem (rr)
	);

	vtpg_cdiv #(.NW(NW_GRAD), .DIV(V_ACTIVE - 1)) u_blue_div (
		.clk (clk),
		.num (ny),
		.quo (bq),
		.rem (br)
	);

	vtpg_cdiv #(.NW(COORD_W), .DIV(H_ACTIVE / 8)) u_col_div (
		.clk (clk),
		.num (pixel_x),
		.quo (cq),
		.rem (cr)
	);

	vtpg_cdiv #(.NW(COORD_W), .DIV(V_ACTIVE / 4)) u_row_div (
		.clk (clk),
		.num (pixel_y),
		.quo (wq),
		.rem (wr)
	);

	// gradient remainders are not needed
	assign grid = '{
		red:      rq[7:0] | {8{rr[0] & 1'b0}},
		blue:     bq[7:0] | {8{br[0] & 1'b0}},
		col:      cq,
		row:      wq,
		col_edge: (cr == '0),
		row_edge: (wr == '0)
	};

	vtpg_color #(.H_ACTIVE(H_ACTIVE), .V_ACTIVE(V_ACTIVE)) u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s3),
		.pix       (pix_s3),
		.grid      (grid),
		.valid_out (done),
		.color     (pixel_color)
	);

endmodule

/* rtl/vtpg_cdiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpg_cdiv
// pipelined division by a constant: reciprocal multiply, then one correction
// ----------------------------------------------------------------------------
module vtpg_cdiv #(
	parameter int NW  = 10,
	parameter int DIV = 3
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	output logic [NW-1:0] quo,
	output logic [NW-1:0] rem
);

	localparam int            DW    = $clog2(DIV + 1);
	localparam int            PW    = 2 * NW + 1;
	localparam int            QW    = NW + DW;
	localparam logic [NW:0]   MULT  = (NW + 1)'((1 << NW) / DIV);
	localparam logic [QW-1:0] DIV_W = QW'(DIV);

	logic [PW-1:0] prod_s1;
	logic [NW-1:0] num_s1;
	logic [NW-1:0] q_est;
	logic [QW-1:0] qd_full;
	logic [NW-1:0] q_s2;
	logic [NW-1:0] qd_s2;
	logic [NW-1:0] num_s2;
	logic [NW-1:0] diff;
	logic [NW-1:0] quo_s3;
	logic [NW-1:0] rem_s3;

	// stage 1: reciprocal product
	always_ff @(posedge clk) begin
		prod_s1 <= PW'(num) * PW'(MULT);
		num_s1  <= num;
	end

	// stage 2: estimate, back multiply
	assign q_est   = prod_s1[2*NW-1:NW];
	assign qd_full = QW'(q_est) * DIV_W;

	always_ff @(posedge clk) begin
		q_s2   <= q_est;
		qd_s2  <= qd_full[NW-1:0];
		num_s2 <= num_s1;
	end

	// stage 3: estimate is low by at most one
	assign diff = num_s2 - qd_s2;

	always_ff @(posedge clk) begin
		if (QW'(diff) >= DIV_W) begin
			quo_s3 <= q_s2 + NW'(1);
			rem_s3 <= NW'(QW'(diff) - DIV_W);
		end else begin
			quo_s3 <= q_s2;
			rem_s3 <= diff;
		end
	end

	assign quo = quo_s3;
	assign rem = rem_s3;

endmodule

/* rtl/vtpg_color.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpg_color
// final stage: picks the pattern color from coordinates and grid terms
// ----------------------------------------------------------------------------
module vtpg_color #(
	parameter int H_ACTIVE = 720,
	parameter int V_ACTIVE = 720
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_in,
	input  vtpg_pkg::pix_t        pix,
	input  vtpg_pkg::grid_t       grid,
	output logic                  valid_out,
	output logic [15:0]           color
);
	import vtpg_pkg::*;

	localparam int EW = 13;
	localparam logic [EW-1:0] H_L   = EW'(H_ACTIVE);
	localparam logic [EW-1:0] V_L   = EW'(V_ACTIVE);
	localparam logic [EW-1:0] HM1   = EW'(H_ACTIVE - 1);
	localparam logic [EW-1:0] VM1   = EW'(V_ACTIVE - 1);
	localparam logic [EW-1:0] HM2   = EW'(H_ACTIVE - 2);
	localparam logic [EW-1:0] VM2   = EW'(V_ACTIVE - 2);
	localparam logic [EW-1:0] H_Q1  = EW'(H_ACTIVE / 4);
	localparam logic [EW-1:0] H_Q2  = EW'(H_ACTIVE / 2);
	localparam logic [EW-1:0] H_Q3  = EW'(H_ACTIVE * 3 / 4);
	localparam logic [EW-1:0] V_Q3  = EW'(V_ACTIVE * 3 / 4);

	logic [EW-1:0]      xe;
	logic [EW-1:0]      ye;
	logic [COORD_W-1:0] xy;
	logic               border1;
	logic [15:0]        c_grad;
	logic [15:0]        c_bars;
	logic [15:0]        c_ladder;
	logic [7:0]         lvl;
	logic [COORD_W-1:0] col_m2;
	logic [15:0]        c_next;
	logic               valid_s4;
	logic [15:0]        color_s4;

	assign xe      = EW'(pix.x);
	assign ye      = EW'(pix.y);
	assign xy      = pix.x ^ pix.y;
	assign border1 = (xe == '0) || (ye == '0) || (xe == HM1) || (ye == VM1);
	assign col_m2  = grid.col - COORD_W'(2);

	always_comb begin
		c_grad = border1 ? WHITE565 : {grid.red[7:3], xy[7:2], grid.blue[7:3]};
	end

	always_comb begin
		priority if (ye >= VM2 || ye <= EW'(1) || xe <= EW'(1) || xe >= HM2) begin
			c_bars = WHITE565;
		end else if (ye > V_Q3) begin
			c_bars = BLACK565;
		end else if (xe < H_Q1) begin
			c_bars = RED565;
		end else if (xe < H_Q2) begin
			c_bars = GREEN565;
		end else if (xe < H_Q3) begin
			c_bars = BLUE565;
		end else begin
			c_bars = WHITE565;
		end
	end

	always_comb begin
		lvl = 8'h00;
		if (grid.col[COORD_W-1:3] == '0) begin
			unique case (grid.col[2:0])
				3'd0: lvl = 8'h80;
				3'd1: lvl = 8'h40;
				3'd2: lvl = 8'h20;
				3'd3: lvl = 8'h10;
				3'd4: lvl = 8'h08;
				3'd5: lvl = (grid.row == COORD_W'(1)) ? 8'h04 : 8'h00;
				3'd6: lvl = 8'h00;
				3'd7: lvl = 8'hFF;
			endcase
		end
		priority if (grid.row == COORD_W'(0)) begin
			c_ladder = {lvl[7:3], 6'd0, 5'd0};
		end else if (grid.row == COORD_W'(1)) begin
			c_ladder = {5'd0, lvl[7:2], 5'd0};
		end else if (grid.row == COORD_W'(2)) begin
			c_ladder = {5'd0, 6'd0, lvl[7:3]};
		end else if (grid.col == COORD_W'(0)) begin
			c_ladder = WHITE565;
		end else if (grid.col == COORD_W'(1)) begin
			c_ladder = GREY565;
		end else if (grid.col == COORD_W'(2)) begin
			c_ladder = BLACK565;
		end else begin
			c_ladder = {col_m2[4:0], 11'd0};
		end
		if (grid.col_edge || grid.row_edge) begin
			c_ladder = BLACK565;
		end
		if (border1) begin
			c_ladder = WHITE565;
		end
	end

	always_comb begin
		if (xe >= H_L || ye >= V_L) begin
			c_next = BLACK565;
		end else begin
			unique case (pix.sel)
				PAT_GRADIENT: c_next = c_grad;
				PAT_BARS:     c_next = c_bars;
				default:      c_next = c_ladder;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		color_s4 <= c_next;
	end

	assign valid_out = valid_s4;
	assign color     = color_s4;

endmodule

/* dv/tb_video_test_pattern_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_video_test_pattern_generator
// self-checking bench for the RGB565 test pattern generator: drives pixel
// coordinates under every pattern selection, works out each pixel color in
// the bench and compares it with the color that comes back, in order
// ----------------------------------------------------------------------------
module tb_video_test_pattern_generator;
	import vtpg_pkg::*;

	localparam int H_ACT  = 720;
	localparam int V_ACT  = 720;
	localparam int CELL_W = H_ACT / 8;
	localparam int CELL_H = V_ACT / 4;

	localparam logic [SEL_W-1:0] PAT_SEL_ZERO = 2'd0;

	localparam int STALL_LIMIT        = 1000;
	localparam int DRAIN_CYCLES       = 8;
	localparam int PIXELS_PER_SETTING = 120;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [SEL_W-1:0]   sel;
		logic [COLOR_W-1:0] color;
	} pixel_rec_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic               cfg_wr_en;
	logic [SEL_W-1:0]   cfg_wr_data;
	logic               done;
	logic [COLOR_W-1:0] pixel_color;

	pixel_rec_t       expected_colors[$];
	logic [SEL_W-1:0] active_pattern;
	int               idle_pct;
	int               error_count  = 0;
	int               stall_cycles = 0;

	video_test_pattern_generator #(
		.H_ACTIVE(H_ACT),
		.V_ACTIVE(V_ACT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done(done),
		.pixel_color(pixel_color)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [COLOR_W-1:0] rgb565(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	function automatic logic [COLOR_W-1:0] gradient_color(input int x, input int y);
		int r;
		int b;
		if (x == 0 || y == 0 || x == H_ACT - 1 || y == V_ACT - 1)
			return WHITE565;
		r = x * 255 / (H_ACT - 1);
		b = y * 255 / (V_ACT - 1);
		return rgb565(8'(r), 8'(x ^ y), 8'(b));
	endfunction

	function automatic logic [COLOR_W-1:0] bars_color(input int x, input int y);
		if (y >= V_ACT - 2 || y <= 1 || x <= 1 || x >= H_ACT - 2)
			return WHITE565;
		if (y > V_ACT * 3 / 4)
			return BLACK565;
		if (x < H_ACT / 4)
			return RED565;
		if (x < H_ACT / 2)
			return GREEN565;
		if (x < H_ACT * 3 / 4)
			return BLUE565;
		return WHITE565;
	endfunction

	function automatic logic [COLOR_W-1:0] ladder_color(input int x, input int y);
		int                 row;
		int                 col;
		logic [7:0]         level;
		logic [COLOR_W-1:0] c;
		if (x == 0 || y == 0 || x == H_ACT - 1 || y == V_ACT - 1)
			return WHITE565;
		row = y / CELL_H;
		col = x / CELL_W;
		if (row < 3) begin
			level = 8'h00;
			if (col < 6)
				level = (col < 5 || row == 1) ? 8'(8'h80 >> col) : 8'h00;
			else if (col == 7)
				level = 8'hFF;
			case (row)
				0: c = rgb565(level, 8'h00, 8'h00);
				1: c = rgb565(8'h00, level, 8'h00);
				default: c = rgb565(8'h00, 8'h00, level);
			endcase
		end else begin
			// bottom row, also taken by any row past the grid
			case (col)
				0: c = WHITE565;
				1: c = GREY565;
				2: c = BLACK565;
				default: c = rgb565(8'((col - 2) << 3), 8'h00, 8'h00);
			endcase
		end
		if (x % CELL_W == 0 || y % CELL_H == 0)
			c = BLACK565;
		return c;
	endfunction

	function automatic logic [COLOR_W-1:0] predict_color(input logic [SEL_W-1:0] sel,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		if (int'(x) >= H_ACT || int'(y) >= V_ACT)
			return BLACK565;
		case (sel)
			PAT_GRADIENT: return gradient_color(int'(x), int'(y));
			PAT_BARS:     return bars_color(int'(x), int'(y));
			default:      return ladder_color(int'(x), int'(y));
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] random_coord(input int span);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
		if (pick < 25) begin
			// borders and just past the active area
			case ($urandom_range(0, 7))
				0: return COORD_W'(0);
				1: return COORD_W'(1);
				2: return COORD_W'(2);
				3: return COORD_W'(span - 3);
				4: return COORD_W'(span - 2);
				5: return COORD_W'(span - 1);
				6: return COORD_W'(span);
				default: return COORD_W'(span + 1);
			endcase
		end
		return COORD_W'($urandom_range(0, span - 1));
	endfunction

	task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		pixel_rec_t rec;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start   <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		do begin
			@(posedge clk);
		end while (busy);
		rec.x     = x;
		rec.y     = y;
		rec.sel   = active_pattern;
		rec.color = predict_color(active_pattern, x, y);
		expected_colors.push_back(rec);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (expected_colors.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_pattern(input logic [SEL_W-1:0] sel);
		wait_drained();
		@(negedge clk);
		cfg_wr_en      <= 1'b1;
		cfg_wr_data    <= sel;
		active_pattern  = sel;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// ladder as selected out of reset
	task automatic test_reset_pattern();
		send_pixel(0, 0);
		send_pixel(90, 50);
		send_pixel(100, 180);
		send_pixel(45, 90);
		send_pixel(500, 270);
		send_pixel(500, 90);
		send_pixel(650, 450);
		send_pixel(45, 600);
		send_pixel(135, 600);
		send_pixel(650, 600);
	endtask

	task automatic test_gradient();
		set_pattern(PAT_GRADIENT);
		send_pixel(1, 1);
		send_pixel(718, 718);
		send_pixel(719, 360);
		send_pixel(355, 300);
		send_pixel(1023, 1023);
	endtask

	task automatic test_bars();
		set_pattern(PAT_BARS);
		send_pixel(1, 100);
		send_pixel(2, 2);
		send_pixel(717, 100);
		send_pixel(180, 100);
		send_pixel(360, 300);
		send_pixel(540, 300);
		send_pixel(300, 540);
		send_pixel(300, 541);
	endtask

	task automatic test_selector_zero();
		set_pattern(PAT_SEL_ZERO);
		send_pixel(500, 270);
		send_pixel(719, 0);
	endtask

	task automatic test_random_pixels();
		int               idle_phases[3] = '{0, 73, 11};
		logic [SEL_W-1:0] settings[5];
		settings = '{PAT_GRADIENT, PAT_BARS, PAT_LADDER, PAT_SEL_ZERO, PAT_LADDER};
		foreach (idle_phases[p]) begin
			idle_pct = idle_phases[p];
			foreach (settings[s]) begin
				if (s == 4)
					set_pattern(SEL_W'($urandom_range(0, 3)));
				else
					set_pattern(settings[s]);
				repeat (PIXELS_PER_SETTING)
					send_pixel(random_coord(H_ACT), random_coord(V_ACT));
			end
		end
	endtask

	always @(posedge clk) begin
		pixel_rec_t rec;
		if (arst_n && done) begin
			if (expected_colors.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual pixel_color %h",
					$time, pixel_color);
				error_count++;
			end else begin
				rec = expected_colors.pop_front();
				if (pixel_color !== rec.color) begin
					$display("%0t: mismatch (sel %0d x %0d y %0d): expected %h, actual %h",
						$time, rec.sel, rec.x, rec.y, rec.color, pixel_color);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		pixel_x        = '0;
		pixel_y        = '0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		active_pattern = PAT_LADDER;
		idle_pct       = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_pattern();
		test_gradient();
		test_bars();
		test_selector_zero();
		test_random_pixels();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* video_test_pattern_generator.f */
rtl/vtpg_pkg.sv
rtl/vtpg_cdiv.sv
rtl/vtpg_color.sv
rtl/video_test_pattern_generator.sv
dv/tb_video_test_pattern_generator.sv
